// ===== rtl/bblc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_pkg
// Shared types and constants of the byte budget lru cache.
// ----------------------------------------------------------------------------
package bblc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int LIVE_W    = $clog2(ENTRIES + 1);
  localparam int TAG_BITS  = 32;
  localparam int BYTES_W   = 40;
  localparam int CNT_W     = 32;
  localparam int EVN_W     = 5;
  localparam logic [BYTES_W-1:0] KIB = 40'd1024;
  localparam logic [BYTES_W-1:0] BUDGET_RESET = KIB * KIB * KIB;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_PUT    = 3'd1,
    OP_DELETE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_TRIM   = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key_tag;
    logic [31:0] value_handle;
    logic [31:0] entry_bytes;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [31:0]        found_handle;
    logic [BYTES_W-1:0] used_bytes;
    logic [4:0]         live_entries;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   eviction_total;
    logic [EVN_W-1:0]   evicted_now;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic evict;
    logic cap_evict;
    logic insert;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_put;
    logic is_trim;
    logic over;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/bblc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_req_if
// Request channel: valid, ready and one operation.
// ----------------------------------------------------------------------------
interface bblc_req_if;
  logic           valid;
  logic           ready;
  bblc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bblc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_rsp_if
// Response channel: valid, ready and one result.
// ----------------------------------------------------------------------------
interface bblc_rsp_if;
  logic           valid;
  logic           ready;
  bblc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bblc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_ctrl
// Sequencer for lookup, eviction walk, insert and result hand-off.
// ----------------------------------------------------------------------------
module bblc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bblc_pkg::status_t status,
  output bblc_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_EVICT  = 6'b000100,
    S_FULL   = 6'b001000,
    S_INSERT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.is_put || status.is_trim) begin
          state_next = S_EVICT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EVICT: begin
        // one least-recent victim per cycle
        if (status.over) begin
          cmd.evict = 1'b1;
        end else if (status.is_put) begin
          state_next = S_FULL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FULL: begin
        cmd.cap_evict = 1'b1;
        state_next    = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bblc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_datapath
// Entry table, recency ranks, byte total, counters and result register.
// ----------------------------------------------------------------------------
module bblc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bblc_pkg::BYTES_W-1:0]        cfg_wdata,
  input  bblc_pkg::req_t                      in_data,
  input  bblc_pkg::cmd_t                      cmd,
  output bblc_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bblc_pkg::rsp_t                      out_data
);

  localparam int N  = bblc_pkg::ENTRIES;
  localparam int IW = bblc_pkg::IDX_W;
  localparam int LW = bblc_pkg::LIVE_W;
  localparam int BW = bblc_pkg::BYTES_W;
  localparam int CW = bblc_pkg::CNT_W;
  localparam int EW = bblc_pkg::EVN_W;

  logic [BW-1:0]                 budget;
  bblc_pkg::req_t                req_q;
  logic [N-1:0]                  valid;
  logic [bblc_pkg::TAG_BITS-1:0] tags [N];
  logic [31:0]                   handles [N];
  logic [31:0]                   sizes [N];
  logic [IW-1:0]                 ranks [N];
  logic [BW-1:0]                 used;
  logic [LW-1:0]                 live;
  logic [CW-1:0]                 hits, misses, evictions;
  logic [EW-1:0]                 evn;
  logic                          hit_q;
  logic [31:0]                   found_q;

  logic [N-1:0]  match_vec, oldest_vec;
  logic          match_any, is_get, is_put, is_del, is_clr, is_trim, full;
  logic [IW-1:0] match_idx, oldest_idx, free_idx, sel_idx, sel_rank;
  logic [31:0]   sel_size;
  logic [BW:0]   demand;
  logic          rem_en, newest_en, evict_cnt;

  assign is_get  = req_q.opcode == bblc_pkg::OP_GET;
  assign is_put  = req_q.opcode == bblc_pkg::OP_PUT;
  assign is_del  = req_q.opcode == bblc_pkg::OP_DELETE;
  assign is_clr  = req_q.opcode == bblc_pkg::OP_CLEAR;
  assign is_trim = req_q.opcode == bblc_pkg::OP_TRIM;
  assign full    = live == LW'(N);

  always_comb begin
    match_idx  = '0;
    oldest_idx = '0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      match_vec[i]  = valid[i] && tags[i] == req_q.key_tag[bblc_pkg::TAG_BITS-1:0];
      // the least-recent entry holds rank live-1
      oldest_vec[i] = valid[i] && {1'b0, ranks[i]} == LW'(live - LW'(1));
      if (match_vec[i]) match_idx = IW'(i);
      if (oldest_vec[i]) oldest_idx = IW'(i);
      if (!valid[i]) free_idx = IW'(i);
    end
  end

  assign match_any = |match_vec;
  assign sel_idx   = cmd.exec ? match_idx : oldest_idx;
  assign sel_rank  = ranks[sel_idx];
  assign sel_size  = sizes[sel_idx];

  // bytes in use plus the incoming size of a put, against the budget
  assign demand = {1'b0, used} + (is_put ? (BW + 1)'(req_q.entry_bytes) : '0);

  assign evict_cnt = cmd.evict || (cmd.cap_evict && full);
  assign rem_en    = evict_cnt || (cmd.exec && match_any && (is_put || is_del));
  assign newest_en = cmd.exec && is_get && match_any;

  assign status.is_put   = is_put;
  assign status.is_trim  = is_trim;
  assign status.over     = live != '0 && demand > {1'b0, budget};
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= bblc_pkg::BUDGET_RESET;
    end else if (cfg_we) begin
      budget <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= in_data;
    end
  end

  // table payload and ranks
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (rem_en) begin
        if (valid[i] && IW'(i) != sel_idx && ranks[i] > sel_rank) begin
          ranks[i] <= ranks[i] - IW'(1);
        end
      end else if (newest_en) begin
        if (IW'(i) == sel_idx) begin
          ranks[i] <= '0;
        end else if (valid[i] && ranks[i] < sel_rank) begin
          ranks[i] <= ranks[i] + IW'(1);
        end
      end else if (cmd.insert) begin
        if (IW'(i) == free_idx) begin
          tags[i]    <= req_q.key_tag[bblc_pkg::TAG_BITS-1:0];
          handles[i] <= req_q.value_handle;
          sizes[i]   <= req_q.entry_bytes;
          ranks[i]   <= '0;
        end else if (valid[i]) begin
          ranks[i] <= ranks[i] + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      used      <= '0;
      live      <= '0;
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
      evn       <= '0;
      hit_q     <= 1'b0;
      found_q   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        evn     <= '0;
        hit_q   <= 1'b0;
        found_q <= '0;
      end
      if (cmd.exec && is_clr) begin
        valid <= '0;
        used  <= '0;
        live  <= '0;
      end else if (rem_en) begin
        valid[sel_idx] <= 1'b0;
        used           <= used - BW'(sel_size);
        live           <= live - LW'(1);
      end else if (cmd.insert) begin
        valid[free_idx] <= 1'b1;
        used            <= used + BW'(req_q.entry_bytes);
        live            <= live + LW'(1);
      end
      if (cmd.exec && is_get) begin
        if (match_any) begin
          hit_q   <= 1'b1;
          found_q <= handles[match_idx];
          if (hits != '1) hits <= hits + CW'(1);
        end else if (misses != '1) begin
          misses <= misses + CW'(1);
        end
      end
      if (evict_cnt) begin
        if (evictions != '1) evictions <= evictions + CW'(1);
        if (evn != '1) evn <= evn + EW'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.hit            <= hit_q;
      out_data.found_handle   <= found_q;
      out_data.used_bytes     <= used;
      out_data.live_entries   <= 5'(live);
      out_data.hit_total      <= hits;
      out_data.miss_total     <= misses;
      out_data.eviction_total <= evictions;
      out_data.evicted_now    <= evn;
    end
  end

endmodule

// ===== rtl/byte_budget_lru_cache.sv =====
`timescale 1ns / 1ps
// sequence: get, delete, clear and other codes go through lookup and result; trim
// adds an eviction walk; put adds the walk, a full-table eviction and an insert;
// the walk removes least-recent entries one by one; one operation is in flight at a time
// a new request is taken while a finished result waits in the output register
// reset: table empty, byte total and counters zero, budget 1 GiB
// ----------------------------------------------------------------------------
// byte_budget_lru_cache
// Size-aware lru cache of tagged entries kept under a byte budget.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bblc_pkg::BYTES_W-1:0] cfg_wdata,
  bblc_req_if.sink                     req,
  bblc_rsp_if.source                   rsp
);

  bblc_pkg::cmd_t    cmd;
  bblc_pkg::status_t status;

  bblc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bblc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (req.data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an operation is in flight");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.data.live_entries <= 5'(bblc_pkg::ENTRIES))
    else $error("live entry count above table size");

  a_hit_live: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.hit |-> rsp.data.live_entries != '0)
    else $error("hit reported on an empty table");

  a_miss_handle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.hit |-> rsp.data.found_handle == '0)
    else $error("handle returned without a hit");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the byte budget lru cache: directed and random operations go in on
// the request channel, and a scoreboard predicts and checks every response.
// ----------------------------------------------------------------------------

class lru_scoreboard;
  localparam int N = bblc_pkg::ENTRIES;
  logic [39:0] budget;
  bit          vld[N];
  logic [31:0] tags[N];
  logic [31:0] hdls[N];
  logic [31:0] sizes[N];
  int          rank[N];
  logic [39:0] used;
  logic [31:0] hits, misses, evicts;
  bblc_pkg::rsp_t pending[$];
  int errors;

  function new();
    budget = bblc_pkg::BUDGET_RESET;
    used = 0; hits = 0; misses = 0; evicts = 0; errors = 0;
    foreach (vld[i]) vld[i] = 0;
  endfunction

  function logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function int live();
    int n;
    n = 0;
    foreach (vld[i]) if (vld[i]) n++;
    return n;
  endfunction

  function int lookup(logic [31:0] t);
    foreach (vld[i]) if (vld[i] && tags[i] == t) return i;
    return -1;
  endfunction

  function int oldest();
    int b;
    b = -1;
    foreach (vld[i]) if (vld[i] && (b < 0 || rank[i] > rank[b])) b = i;
    return b;
  endfunction

  function void drop(int s);
    vld[s] = 0;
    used = used - {8'd0, sizes[s]};
    foreach (vld[i]) if (vld[i] && rank[i] > rank[s]) rank[i]--;
  endfunction

  function int shed(logic [39:0] incoming);
    int n, v;
    n = 0;
    forever begin
      v = oldest();
      if (v < 0 || {1'b0, used} + {1'b0, incoming} <= {1'b0, budget}) break;
      drop(v);
      evicts = bump(evicts);
      n++;
    end
    return n;
  endfunction

  function void note(bblc_pkg::req_t r);
    bblc_pkg::rsp_t e;
    int s, n;
    e = '0;
    n = 0;
    case (r.opcode)
      bblc_pkg::OP_GET: begin
        s = lookup(r.key_tag);
        if (s >= 0) begin
          hits = bump(hits);
          foreach (vld[i]) if (vld[i] && i != s && rank[i] < rank[s]) rank[i]++;
          rank[s] = 0;
          e.hit = 1'b1;
          e.found_handle = hdls[s];
        end else misses = bump(misses);
      end
      bblc_pkg::OP_PUT: begin
        s = lookup(r.key_tag);
        if (s >= 0) drop(s);
        n = shed({8'd0, r.entry_bytes});
        if (live() >= N) begin
          drop(oldest());
          evicts = bump(evicts);
          n++;
        end
        for (s = 0; s < N; s++) if (!vld[s]) break;
        foreach (vld[i]) if (vld[i]) rank[i]++;
        vld[s] = 1; tags[s] = r.key_tag; hdls[s] = r.value_handle;
        sizes[s] = r.entry_bytes; rank[s] = 0;
        used = used + {8'd0, r.entry_bytes};
      end
      bblc_pkg::OP_DELETE: begin
        s = lookup(r.key_tag);
        if (s >= 0) drop(s);
      end
      bblc_pkg::OP_CLEAR: begin
        foreach (vld[i]) vld[i] = 0;
        used = 0;
      end
      bblc_pkg::OP_TRIM: n = shed(40'd0);
      default: ;
    endcase
    e.used_bytes = used;
    e.live_entries = 5'(live());
    e.hit_total = hits;
    e.miss_total = misses;
    e.eviction_total = evicts;
    e.evicted_now = 5'((n > 31) ? 31 : n);
    pending.push_back(e);
  endfunction

  function void check(bblc_pkg::rsp_t a);
    bblc_pkg::rsp_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response %p", a);
      return;
    end
    e = pending.pop_front();
    if (a !== e) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
    end
  endfunction
endclass

module tb;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [39:0] cfg_wdata;
  bblc_req_if  req ();
  bblc_rsp_if  rsp ();
  lru_scoreboard board;
  bit          hold_rsp;
  longint      cycles;
  logic [31:0] key_pool[8];

  byte_budget_lru_cache dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic send(logic [2:0] op, logic [31:0] k, logic [31:0] h, logic [31:0] b);
    bblc_pkg::req_t r;
    r = '{opcode: op, key_tag: k, value_handle: h, entry_bytes: b};
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0) @(posedge clk);
    req.valid <= 1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    board.note(r);
    req.valid <= 0;
    // ready is low after a transaction anyway, while the operation is in flight
    @(posedge clk);
  endtask

  task automatic set_budget(logic [39:0] v);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.budget = v;
  endtask

  task automatic random_op(bit wide);
    int pick;
    logic [31:0] k, sz;
    pick = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
    sz = wide ? $urandom : $urandom_range(0, 600);
    if (pick < 35) send(bblc_pkg::OP_GET, k, $urandom, $urandom);
    else if (pick < 80) send(bblc_pkg::OP_PUT, k, $urandom, sz);
    else if (pick < 90) send(bblc_pkg::OP_DELETE, k, $urandom, $urandom);
    else if (pick < 93) send(bblc_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    else if (pick < 98) send(bblc_pkg::OP_TRIM, $urandom, $urandom, $urandom);
    else send(3'($urandom_range(5, 7)), k, $urandom, $urandom);
  endtask

  // response side: a drawn wait after each transaction, plus one long hold
  initial begin
    int gap;
    rsp.ready = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        board.check(rsp.data);
        gap = $urandom_range(0, 14);
      end else if (gap > 0 && !hold_rsp) begin
        gap--;
      end
      rsp.ready <= !hold_rsp && gap == 0;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1000000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    rst = 1; cfg_we = 0; cfg_wdata = '0; hold_rsp = 0;
    req.valid = 0; req.data = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes and special cases
    send(bblc_pkg::OP_GET, 32'h0, 0, 0);
    send(bblc_pkg::OP_TRIM, 0, 0, 0);
    send(bblc_pkg::OP_DELETE, 32'h1234, 0, 0);
    send(bblc_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(bblc_pkg::OP_GET, 32'h0, 0, 0);
    send(bblc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send(bblc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'd100);
    send(bblc_pkg::OP_GET, 32'hFFFF_FFFF, 0, 0);
    send(3'd5, 0, 0, 0);
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 18; i++) send(bblc_pkg::OP_PUT, 32'h100 + i, i, 16);
    send(bblc_pkg::OP_DELETE, 32'h111, 0, 0);
    send(bblc_pkg::OP_CLEAR, 0, 0, 0);
    set_budget(40'd0);
    send(bblc_pkg::OP_PUT, 32'h5, 1, 7);
    send(bblc_pkg::OP_PUT, 32'h6, 2, 0);
    send(bblc_pkg::OP_TRIM, 0, 0, 0);
    set_budget(40'hFF_FFFF_FFFF);
    for (int i = 0; i < 17; i++) send(bblc_pkg::OP_PUT, 32'h200 + i, i, 32'hFFFF_FFFF);

    // long hold on the response side while requests keep coming
    fork
      begin
        hold_rsp = 1;
        repeat (300) @(posedge clk);
        hold_rsp = 0;
      end
      for (int i = 0; i < 20; i++) random_op(0);
    join

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_budget(40'd1000);
        1: set_budget(40'd3000);
        2: set_budget(40'd0);
        3: set_budget(40'hFF_FFFF_FFFF);
        4: set_budget(40'($urandom) << 8);
        default: set_budget(bblc_pkg::BUDGET_RESET);
      endcase
      for (int i = 0; i < 300; i++) random_op(ph >= 3);
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
